// ----- rtl/core/bpa_pkg.sv -----
package bpa_pkg;

  localparam int WORD_COUNT_DEF = 1024;
  localparam int WORD_BITS_DEF  = 64;

  // one summary bit per map word, marking the word full
  localparam int SUM_BITS = 32;
  localparam int SUM_LOG  = 5;

  localparam int PAGE_LIMIT = 65536;

  localparam logic [16:0] PAGE_TOTAL_RST = 17'd65536;
  localparam logic [16:0] RESERVED_RST   = 17'd256;
  localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic cfg_index_t;
  localparam cfg_index_t CFG_PAGE_TOTAL = 1'b0;
  localparam cfg_index_t CFG_RESERVED   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_BAD_PAGE = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] page_number;
  } in_req_t;

  typedef struct packed {
    logic [15:0] page_given;
    logic [1:0]  status;
    logic [16:0] free_count;
  } out_rsp_t;

endpackage

// ----- rtl/core/bitmap_page_allocator.sv -----
// First-fit physical page allocator over a one-bit-per-page used map.
// Request channel: in_data is taken at a rising edge with start high and busy
// low. operation 0 allocates the lowest free page at or above reserved_below
// and below page_total; operation 1 frees in_data.page_number.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver cannot stall it, so it must take every result when shown.
// Config channel: cfg_index 0 writes page_total, 1 writes reserved_below;
// cfg_ready is always high. Write only while busy is low.
// Steps: a free passes S_DIV1, S_DIV2, S_FREAD, S_FCHK and S_DONE; S_DIV2
// goes straight to S_DONE when the page is reserved or out of range. An
// allocate reads summary entries one per cycle (32 map words each), then the
// first non-full map word, and goes back to the summary scan when that word
// holds free pages only below reserved_below; out of memory comes from S_DIV2
// when reserved_below is at or above the total, or when the scan runs off the
// map. The single map read port and the serial summary scan set the pace.
// busy drops in the cycle the result is shown, so the next request can be
// taken while the result is on the ports.
// Reset: after rst_n is released the map is cleared one word per cycle,
// with busy high until all WORD_COUNT words are clear; page_total resets to
// 65536 and reserved_below to 256.
module bitmap_page_allocator #(
  parameter int WORD_COUNT = bpa_pkg::WORD_COUNT_DEF,
  parameter int WORD_BITS  = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bpa_pkg::in_req_t    in_data,
  output logic                out_valid,
  output bpa_pkg::out_rsp_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bpa_pkg::cfg_index_t cfg_index,
  input  logic [16:0]         cfg_data
);

  localparam int SB          = bpa_pkg::SUM_BITS;
  localparam int SL          = bpa_pkg::SUM_LOG;
  localparam int WI          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BI          = $clog2(WORD_BITS);
  localparam int SUM_COUNT   = (WORD_COUNT + SB - 1) / SB;
  localparam int SI          = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
  localparam int XW          = SI + SL + 1;
  localparam int MAP_PAGES   = WORD_COUNT * WORD_BITS;
  localparam int CAP         = (MAP_PAGES < bpa_pkg::PAGE_LIMIT) ? MAP_PAGES
                                                                  : bpa_pkg::PAGE_LIMIT;
  localparam int PW          = $clog2(MAP_PAGES) + 1;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (2 ** RECIP_SHIFT + WORD_BITS - 1) / WORD_BITS;
  localparam int RW          = $clog2(RECIP + 1);
  localparam int PRW         = 17 + RW;
  localparam int QW          = PRW - RECIP_SHIFT;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_SREAD, S_SCHK, S_DREAD,
    S_DCHK, S_PCHK, S_FREAD, S_FCHK, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [16:0]       page_total_r, page_total_nxt;
  logic [16:0]       reserved_r, reserved_nxt;
  logic [16:0]       used_count_r, used_count_nxt;
  logic [WI-1:0]     ctr_r, ctr_nxt;
  logic              op_r, op_nxt;
  logic [15:0]       pn_r, pn_nxt;
  logic [PRW-1:0]    prod_r, prod_nxt;
  logic [XW-1:0]     rw_r, rw_nxt;
  logic [BI-1:0]     rb_r, rb_nxt;
  logic [XW-1:0]     sw_r, sw_nxt;
  logic [SI-1:0]     sidx_r, sidx_nxt;
  logic [WI-1:0]     w_r, w_nxt;
  logic [BI-1:0]     b_r, b_nxt;
  logic [15:0]       given_r, given_nxt;
  bpa_pkg::status_t  status_r, status_nxt;
  logic [16:0]       free_r, free_nxt;
  logic              out_valid_r, out_valid_nxt;

  // memories
  logic [WORD_BITS-1:0] map_mem [WORD_COUNT];
  logic [SB-1:0]        sum_mem [SUM_COUNT];
  logic [WORD_BITS-1:0] map_rd_r;
  logic [SB-1:0]        sum_rd_r;

  logic                 map_we, map_re;
  logic [WI-1:0]        map_waddr, map_raddr;
  logic [WORD_BITS-1:0] map_wdata;
  logic                 sum_we, sum_re;
  logic [SI-1:0]        sum_waddr, sum_raddr;
  logic [SB-1:0]        sum_wdata;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_r <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    if (sum_re) begin
      sum_rd_r <= sum_mem[sum_raddr];
    end
  end

  // datapath helpers
  logic [16:0]          hi;
  logic [16:0]          div_x;
  logic [QW-1:0]        quo;
  logic [16:0]          rem;
  logic [SB-1:0]        s_vec;
  logic                 s_found;
  logic [SL-1:0]        s_pos;
  logic                 low_sel;
  logic [WORD_BITS-1:0] d_vec;
  logic                 d_found;
  logic [BI-1:0]        d_pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic [SB-1:0]        sum_mask;
  logic [XW-1:0]        next_word;
  logic [PW-1:0]        page;
  logic [16:0]          rest;

  assign hi    = (page_total_r > 17'(CAP)) ? 17'(CAP) : page_total_r;
  assign div_x = (op_r == bpa_pkg::OP_FREE) ? {1'b0, pn_r} : reserved_r;
  assign quo   = prod_r[PRW-1:RECIP_SHIFT];
  assign rem   = div_x - 17'(17'(quo) * 17'(WORD_BITS));

  // summary entry: words below the search start or past the map count as full
  always_comb begin
    s_found = 1'b0;
    s_pos   = '0;
    for (int j = 0; j < SB; j++) begin
      s_vec[j] = sum_rd_r[j]
               | (XW'({sidx_r, SL'(j)}) < sw_r)
               | (XW'({sidx_r, SL'(j)}) >= XW'(WORD_COUNT));
    end
    for (int j = SB - 1; j >= 0; j--) begin
      if (!s_vec[j]) begin
        s_found = 1'b1;
        s_pos   = SL'(j);
      end
    end
  end

  // map word: in the reserved boundary word, pages below the boundary are skipped
  always_comb begin
    low_sel = (XW'(w_r) == rw_r);
    d_found = 1'b0;
    d_pos   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      d_vec[i] = map_rd_r[i] | (low_sel && (BI'(i) < rb_r));
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!d_vec[i]) begin
        d_found = 1'b1;
        d_pos   = BI'(i);
      end
    end
  end

  assign bit_mask  = WORD_BITS'(1) << b_r;
  assign sum_mask  = SB'(1) << SL'(w_r);
  assign next_word = XW'(w_r) + XW'(1);
  assign page      = PW'(PW'(w_r) * PW'(WORD_BITS)) + PW'(b_r);
  assign rest      = hi - reserved_r;

  always_comb begin
    state_nxt      = state_r;
    page_total_nxt = page_total_r;
    reserved_nxt   = reserved_r;
    used_count_nxt = used_count_r;
    ctr_nxt        = ctr_r;
    op_nxt         = op_r;
    pn_nxt         = pn_r;
    prod_nxt       = prod_r;
    rw_nxt         = rw_r;
    rb_nxt         = rb_r;
    sw_nxt         = sw_r;
    sidx_nxt       = sidx_r;
    w_nxt          = w_r;
    b_nxt          = b_r;
    given_nxt      = given_r;
    status_nxt     = status_r;
    free_nxt       = free_r;
    out_valid_nxt  = 1'b0;
    map_we         = 1'b0;
    map_re         = 1'b0;
    map_waddr      = w_r;
    map_raddr      = w_r;
    map_wdata      = map_rd_r;
    sum_we         = 1'b0;
    sum_re         = 1'b0;
    sum_waddr      = SI'(w_r >> SL);
    sum_raddr      = sidx_r;
    sum_wdata      = sum_rd_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpa_pkg::CFG_PAGE_TOTAL: page_total_nxt = cfg_data;
        bpa_pkg::CFG_RESERVED:   reserved_nxt   = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = ctr_r;
        map_wdata = '0;
        sum_we    = 1'b1;
        sum_waddr = SI'(ctr_r >> SL);
        sum_wdata = '0;
        ctr_nxt   = ctr_r + WI'(1);
        if (ctr_r == WI'(WORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_data.operation;
          pn_nxt    = in_data.page_number;
          given_nxt = '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        prod_nxt  = PRW'(PRW'(div_x) * PRW'(RECIP));
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        rw_nxt   = XW'(quo);
        rb_nxt   = BI'(rem);
        sw_nxt   = XW'(quo);
        sidx_nxt = SI'(XW'(quo) >> SL);
        w_nxt    = WI'(quo);
        b_nxt    = BI'(rem);
        if (op_r == bpa_pkg::OP_ALLOC) begin
          if (reserved_r >= hi) begin
            status_nxt = bpa_pkg::ST_NO_MEM;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SREAD;
          end
        end else begin
          if (({1'b0, pn_r} < reserved_r) || ({1'b0, pn_r} >= hi)) begin
            status_nxt = bpa_pkg::ST_BAD_PAGE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_FREAD;
          end
        end
      end
      S_SREAD: begin
        sum_re    = 1'b1;
        sum_raddr = sidx_r;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (s_found) begin
          w_nxt     = WI'({sidx_r, s_pos});
          state_nxt = S_DREAD;
        end else if (sidx_r == SI'(SUM_COUNT - 1)) begin
          status_nxt = bpa_pkg::ST_NO_MEM;
          state_nxt  = S_DONE;
        end else begin
          sum_re    = 1'b1;
          sum_raddr = sidx_r + SI'(1);
          sidx_nxt  = sidx_r + SI'(1);
        end
      end
      S_DREAD: begin
        map_re    = 1'b1;
        map_raddr = w_r;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (d_found) begin
          b_nxt     = d_pos;
          state_nxt = S_PCHK;
        end else if (next_word == XW'(WORD_COUNT)) begin
          status_nxt = bpa_pkg::ST_NO_MEM;
          state_nxt  = S_DONE;
        end else begin
          sw_nxt    = next_word;
          sidx_nxt  = SI'(next_word >> SL);
          state_nxt = S_SREAD;
        end
      end
      S_PCHK: begin
        state_nxt = S_DONE;
        if (page >= PW'(hi)) begin
          status_nxt = bpa_pkg::ST_NO_MEM;
        end else begin
          map_we     = 1'b1;
          map_waddr  = w_r;
          map_wdata  = map_rd_r | bit_mask;
          sum_we     = ((map_rd_r | bit_mask) == {WORD_BITS{1'b1}});
          sum_waddr  = SI'(w_r >> SL);
          sum_wdata  = sum_rd_r | sum_mask;
          given_nxt  = page[15:0];
          status_nxt = bpa_pkg::ST_OK;
          if (used_count_r != bpa_pkg::COUNT_MAX) begin
            used_count_nxt = used_count_r + 17'd1;
          end
        end
      end
      S_FREAD: begin
        map_re    = 1'b1;
        map_raddr = w_r;
        sum_re    = 1'b1;
        sum_raddr = SI'(w_r >> SL);
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        state_nxt = S_DONE;
        if (!map_rd_r[b_r]) begin
          status_nxt = bpa_pkg::ST_NOT_USED;
        end else begin
          map_we     = 1'b1;
          map_waddr  = w_r;
          map_wdata  = map_rd_r & ~bit_mask;
          sum_we     = 1'b1;
          sum_waddr  = SI'(w_r >> SL);
          sum_wdata  = sum_rd_r & ~sum_mask;
          status_nxt = bpa_pkg::ST_OK;
          if (used_count_r != 17'd0) begin
            used_count_nxt = used_count_r - 17'd1;
          end
        end
      end
      S_DONE: begin
        if ((reserved_r >= hi) || (used_count_r >= rest)) begin
          free_nxt = '0;
        end else begin
          free_nxt = rest - used_count_r;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ctr_r        <= '0;
      page_total_r <= bpa_pkg::PAGE_TOTAL_RST;
      reserved_r   <= bpa_pkg::RESERVED_RST;
      used_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ctr_r        <= ctr_nxt;
      page_total_r <= page_total_nxt;
      reserved_r   <= reserved_nxt;
      used_count_r <= used_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    pn_r     <= pn_nxt;
    prod_r   <= prod_nxt;
    rw_r     <= rw_nxt;
    rb_r     <= rb_nxt;
    sw_r     <= sw_nxt;
    sidx_r   <= sidx_nxt;
    w_r      <= w_nxt;
    b_r      <= b_nxt;
    given_r  <= given_nxt;
    status_r <= status_nxt;
    free_r   <= free_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_comb begin
    out_data.page_given = given_r;
    out_data.status     = status_r;
    out_data.free_count = free_r;
  end

`ifndef SYNTHESIS
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= 17'(CAP))
    else $error("used count above map capacity");

  a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (op_r == bpa_pkg::OP_ALLOC) && (status_r == bpa_pkg::ST_OK))
    |-> (({1'b0, given_r} >= reserved_r) && ({1'b0, given_r} < hi)))
    else $error("allocated page outside usable range");
`endif

endmodule
